// ===== hdl/fplm_pkg.sv =====
`default_nettype none
package fplm_pkg;

  localparam int IDX_W       = 8;
  localparam int DATA_W      = 16;
  localparam int ACC_W       = 32;
  localparam int SHIFT_W     = 5;
  localparam int LEN_CMP_W   = 13;   // holds any legal store length (up to 4096)

  localparam int DEF_VECTOR_LEN = 256;

  // Command queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [DATA_W-1:0] I16_MIN  = 16'sh8000;
  localparam logic signed [DATA_W-1:0] I16_MAX  = 16'sh7fff;
  localparam logic signed [ACC_W-1:0]  SAT_LO   = -32'sd32768;
  localparam logic signed [ACC_W-1:0]  SAT_HI   = 32'sd32767;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TERM = 1'b1
  } func_t;

  // Classified item as it sits in the queue.
  typedef struct packed {
    logic                     is_term;
    logic                     in_range;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] bias;
    logic                     last;
  } cmd_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              push;
    logic              pop;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== hdl/fixed_point_layer_mac_top.sv =====
// Latency: a row-end term passes the queue, then the read, product, row-sum and output registers.
// Throughput: one item per cycle, loads and terms alike, unless a result
//   waits; activation RAM (one access per item) and multiplier set the rate.
// Reset: rst_n synchronous, active low; clears queue, pipe valids,
//   accumulator and result_shift. Activation store is not cleared (no sweep).
`default_nettype none
module fixed_point_layer_mac_top
  import fplm_pkg::*;
#(
  parameter int VECTOR_LEN = DEF_VECTOR_LEN
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input item channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_func,
  input  wire logic [IDX_W-1:0]         in_index,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic signed [DATA_W-1:0] in_row_bias,
  input  wire logic                     in_row_end,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_row_result,
  // config: result_shift
  input  wire logic                     cfg_we,
  input  wire logic [SHIFT_W-1:0]       cfg_wdata
);

  // Front: takes items, flags term vs load and index range, queues them.
  // Back:  pops one item a cycle unless a result waits; a load writes the
  //        store, a term reads it, multiplies, accumulates; on row end the sum
  //        is shifted, clamped, biased and put in the output register.
  // The queue lets input keep flowing while the back holds a waiting result.

  logic               q_valid;
  cmd_t               q_cmd;
  logic               q_pop;
  q_stat_t            q_stat;
  logic [SHIFT_W-1:0] result_shift_r;

  // user changes shift only while idle (block does not enforce it); no staging
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      result_shift_r <= '0;
    end else if (cfg_we) begin
      result_shift_r <= cfg_wdata;
    end
  end

  fplm_front #(
    .VECTOR_LEN (VECTOR_LEN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_func),
    .in_index    (in_index),
    .in_value    (in_value),
    .in_row_bias (in_row_bias),
    .in_row_end  (in_row_end),
    .q_pop       (q_pop),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_stat      (q_stat)
  );

  fplm_back #(
    .VECTOR_LEN (VECTOR_LEN)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .result_shift   (result_shift_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row_result (out_row_result)
  );

`ifndef SYNTHESIS
  // no stale result survives reset
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue overflow");

  // occupancy tracks pushes and pops exactly
  a_q_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> q_stat.count ==
      $past(q_stat.count) + QCNT_W'($past(q_stat.push)) - QCNT_W'($past(q_stat.pop)))
    else $error("queue count mismatch");
`endif

endmodule
`default_nettype wire

// ===== hdl/fplm_ram.sv =====
`default_nettype none
module fplm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/fplm_front.sv =====
`default_nettype none
module fplm_front
  import fplm_pkg::*;
#(
  parameter int VECTOR_LEN = DEF_VECTOR_LEN
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_func,
  input  wire logic [IDX_W-1:0]         in_index,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic signed [DATA_W-1:0] in_row_bias,
  input  wire logic                     in_row_end,
  input  wire logic                     q_pop,
  output logic                          q_valid,
  output cmd_t                          q_cmd,
  output q_stat_t                       q_stat
);

  localparam logic [LEN_CMP_W-1:0] LEN = LEN_CMP_W'(VECTOR_LEN);

  cmd_t              mem_r [QUEUE_DEPTH];
  cmd_t              cmd;
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;

  // classify
  always_comb begin
    cmd.is_term  = (in_func == FUNC_TERM);
    cmd.in_range = ({{(LEN_CMP_W-IDX_W){1'b0}}, in_index} < LEN);
    cmd.index    = in_index;
    cmd.value    = in_value;
    cmd.bias     = in_row_bias;
    cmd.last     = in_row_end;
  end

  assign in_ready = (count_r < QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd;
    end
  end

  assign q_stat.count = count_r;
  assign q_stat.push  = push;
  assign q_stat.pop   = pop;

endmodule
`default_nettype wire

// ===== hdl/fplm_back.sv =====
`default_nettype none
module fplm_back
  import fplm_pkg::*;
#(
  parameter int VECTOR_LEN = DEF_VECTOR_LEN,
  parameter int AW         = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_valid,
  input  wire cmd_t                     q_cmd,
  output logic                          q_pop,
  input  wire logic [SHIFT_W-1:0]       result_shift,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_row_result
);

  logic                     advance;
  logic                     issue;
  logic                     wr_en;
  logic                     rd_en;
  logic [AW-1:0]            addr;
  logic [DATA_W-1:0]        rd_data;

  // stage 1: activation read in flight
  logic                     v1_r;
  logic                     in_range1_r;
  logic signed [DATA_W-1:0] wgt1_r;
  logic signed [DATA_W-1:0] bias1_r;
  logic                     last1_r;
  // stage 2: product
  logic                     v2_r;
  logic signed [ACC_W-1:0]  prod2_r, prod2_nxt;
  logic signed [DATA_W-1:0] bias2_r;
  logic                     last2_r;
  logic signed [DATA_W-1:0] act;
  // stage 3: finished row sum
  logic                     v3_r;
  logic signed [ACC_W-1:0]  sum3_r;
  logic signed [DATA_W-1:0] bias3_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  sum;
  // output
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_row_result_r, out_row_result_nxt;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [DATA_W-1:0] sat;

  // whole pipe moves together; it only holds while a result waits
  assign advance = !out_valid_r || out_ready;
  assign q_pop   = advance && q_valid;
  assign issue   = q_pop;
  assign addr    = AW'(q_cmd.index);
  assign wr_en   = issue && !q_cmd.is_term && q_cmd.in_range;
  assign rd_en   = issue && q_cmd.is_term;

  fplm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VECTOR_LEN),
    .AW    (AW)
  ) u_act_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (q_cmd.value),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_comb begin
    act       = in_range1_r ? $signed(rd_data) : '0;
    prod2_nxt = ACC_W'(act) * ACC_W'(wgt1_r);
    sum       = acc_r + prod2_r;
    acc_nxt   = acc_r;
    if (v2_r) begin
      acc_nxt = last2_r ? '0 : sum;
    end
  end

  // shift, clamp to int16, add bias with wrap
  always_comb begin
    shifted = sum3_r >>> result_shift;
    if (shifted < SAT_LO) begin
      sat = I16_MIN;
    end else if (shifted > SAT_HI) begin
      sat = I16_MAX;
    end else begin
      sat = shifted[DATA_W-1:0];
    end
    out_row_result_nxt = sat + bias3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (advance) begin
      v1_r        <= issue && q_cmd.is_term;
      v2_r        <= v1_r;
      v3_r        <= v2_r && last2_r;
      out_valid_r <= v3_r;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_range1_r      <= q_cmd.in_range;
      wgt1_r           <= q_cmd.value;
      bias1_r          <= q_cmd.bias;
      last1_r          <= q_cmd.last;
      prod2_r          <= prod2_nxt;
      bias2_r          <= bias1_r;
      last2_r          <= last1_r;
      sum3_r           <= sum;
      bias3_r          <= bias2_r;
      out_row_result_r <= out_row_result_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_result = out_row_result_r;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
  import fplm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT = 5000;
  // settle time after the last result; loads give no result
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    func_t                    func;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] bias;
    logic                     last;
  } mac_item_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_func;
  logic [IDX_W-1:0]         in_index;
  logic signed [DATA_W-1:0] in_value;
  logic signed [DATA_W-1:0] in_row_bias;
  logic                     in_row_end;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_row_result;
  logic                     cfg_we;
  logic [SHIFT_W-1:0]       cfg_wdata;

  fixed_point_layer_mac_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_index      (in_index),
    .in_value      (in_value),
    .in_row_bias   (in_row_bias),
    .in_row_end    (in_row_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_result(out_row_result),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // stimulus queue, filled ahead of time by the sequencer below
  mac_item_t pending_q[$];
  // row results still owed by the block, oldest first
  logic signed [DATA_W-1:0] row_result_q[$];

  // shadow of the block: activations, running row sum, shift register
  logic signed [DATA_W-1:0] act_shadow [0:DEF_VECTOR_LEN-1];
  logic [ACC_W-1:0]         row_sum;
  logic [SHIFT_W-1:0]       shift_cfg;
  // which activations the sequencer has loaded (terms only read these)
  bit                       loaded [0:DEF_VECTOR_LEN-1];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned pushed_cnt;
  int unsigned accepted_cnt;
  int unsigned load_cnt;
  int unsigned term_cnt;
  int unsigned rows_checked;
  int unsigned err_cnt;
  int unsigned shift_writes;
  int unsigned stall_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor: applies one accepted item to the shadow state and queues
  // the row result when the item closes a row.
  // ---------------------------------------------------------------------
  function automatic void mac_predict(input func_t f, input logic [IDX_W-1:0] idx,
                                      input logic signed [DATA_W-1:0] val,
                                      input logic signed [DATA_W-1:0] bias,
                                      input logic last);
    logic signed [ACC_W-1:0]  prod;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [DATA_W-1:0] clipped;
    if (f == FUNC_LOAD) begin
      act_shadow[idx] = val;   // bias and row_end are don't-care on loads
      return;
    end
    prod    = ACC_W'(act_shadow[idx]) * ACC_W'(val);
    row_sum = row_sum + prod;  // 32-bit wrap
    if (!last) return;
    shifted = $signed(row_sum) >>> shift_cfg;
    if (shifted < SAT_LO)      clipped = I16_MIN;
    else if (shifted > SAT_HI) clipped = I16_MAX;
    else                       clipped = shifted[DATA_W-1:0];
    row_result_q.push_back(clipped + bias);  // 16-bit wrap on bias add
    row_sum = '0;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: pops pending items, holds valid and payload until accepted.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    mac_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        mac_predict(func_t'(in_func), in_index, in_value, in_row_bias, in_row_end);
        if (in_func == FUNC_LOAD) load_cnt++;
        else term_cnt++;
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_q.pop_front();
          in_func     <= it.func;
          in_index    <= it.index;
          in_value    <= it.value;
          in_row_bias <= it.bias;
          in_row_end  <= it.last;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, compares each result with the oldest
  // expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (row_result_q.size() == 0) begin
          $error("row_result: unexpected result %0d, none pending", out_row_result);
          err_cnt++;
        end else begin
          want = row_result_q.pop_front();
          rows_checked++;
          if (out_row_result !== want) begin
            $error("row_result mismatch: expected %0d, actual %0d", want, out_row_result);
            err_cnt++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // hang detection: count cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------
  task automatic push_item(input func_t f, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] bias,
                           input logic last);
    mac_item_t it;
    it.func  = f;
    it.index = idx;
    it.value = val;
    it.bias  = bias;
    it.last  = last;
    pending_q.push_back(it);
    pushed_cnt++;
    if (f == FUNC_LOAD) loaded[idx] = 1'b1;
  endtask

  // biased toward the corners so saturation and wrap show up often
  function automatic logic [DATA_W-1:0] rand_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return {{8{r[7]}}, r[7:0]};  // small magnitude, keeps sums in range
      default: return r[DATA_W-1:0];
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_loaded();
    logic [IDX_W-1:0] idx;
    do idx = IDX_W'($urandom_range(DEF_VECTOR_LEN - 1)); while (!loaded[idx]);
    return idx;
  endfunction

  task automatic push_noise_load();
    push_item(FUNC_LOAD, IDX_W'($urandom_range(DEF_VECTOR_LEN - 1)), rand_word(),
              DATA_W'($urandom), 1'($urandom_range(1)));
  endtask

  // burst of loads: each lands in a contiguous block (for dense rows) or scattered
  task automatic gen_load_burst();
    int unsigned len;
    logic [IDX_W-1:0] base;
    len  = $urandom_range(1, 8);
    base = IDX_W'($urandom_range(DEF_VECTOR_LEN - 1));
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(1)) begin
        push_item(FUNC_LOAD, base + IDX_W'(k), rand_word(), DATA_W'($urandom),
                  1'($urandom_range(1)));
      end else begin
        push_noise_load();
      end
    end
  endtask

  // one output row: dense walks consecutive loaded entries, sparse jumps;
  // a stray load now and then lands mid-row
  task automatic gen_row();
    int unsigned len;
    bit dense;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] nxt;
    len   = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
    dense = 1'($urandom_range(1));
    idx   = pick_loaded();
    for (int unsigned k = 0; k < len; k++) begin
      if (k > 0 && $urandom_range(9) == 0) push_noise_load();
      nxt = idx + IDX_W'(1);
      if (k > 0) idx = (dense && loaded[nxt]) ? nxt : pick_loaded();
      push_item(FUNC_TERM, idx, rand_word(), rand_word(), k == len - 1);
    end
  endtask

  task automatic gen_random(input int unsigned n);
    int unsigned start;
    start = pushed_cnt;
    while (pushed_cnt - start < n) begin
      if ($urandom_range(99) < 30) gen_load_burst();
      else gen_row();
    end
  endtask

  // block idle: everything accepted, every result back, pipe flushed
  task automatic drain();
    while (!(accepted_cnt == pushed_cnt && row_result_q.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_shift(input logic [SHIFT_W-1:0] s);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shift_cfg = s;
    shift_writes++;
  endtask

  task automatic run_phase(input logic [SHIFT_W-1:0] s, input int unsigned s_idle,
                           input int unsigned r_stall, input int unsigned n,
                           input bit hold_mid);
    drain();
    write_shift(s);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    if (hold_mid) begin
      // sender holds off mid-phase until every owed result is back
      gen_random(n / 2);
      drain();
      gen_random(n - n / 2);
    end else begin
      gen_random(n);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_LOAD;
    in_index       = '0;
    in_value       = '0;
    in_row_bias    = '0;
    in_row_end     = 1'b0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    row_sum        = '0;
    shift_cfg      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (loaded[i]) loaded[i] = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners at shift 0
    write_shift(5'd0);
    push_item(FUNC_LOAD, 8'd0,   16'h7fff, 16'h7fff, 1'b1);  // bias/row_end ignored
    push_item(FUNC_LOAD, 8'd255, 16'h8000, 16'h0000, 1'b0);
    push_item(FUNC_LOAD, 8'd1,   16'd1,    16'h8000, 1'b1);
    push_item(FUNC_LOAD, 8'd2,   16'hffff, 16'h0000, 1'b0);
    push_item(FUNC_LOAD, 8'd170, 16'd100,  16'h5555, 1'b0);
    push_item(FUNC_LOAD, 8'd85,  16'hff9c, 16'haaaa, 1'b1);
    // max*max saturates high; min*max saturates low
    push_item(FUNC_TERM, 8'd0,   16'h7fff, 16'h0000, 1'b1);
    push_item(FUNC_TERM, 8'd255, 16'h7fff, 16'h0000, 1'b1);
    // min*min = 2^30, saturates high, bias -1
    push_item(FUNC_TERM, 8'd255, 16'h8000, 16'hffff, 1'b1);
    // single zero-weight term: bias alone
    push_item(FUNC_TERM, 8'd1,   16'h0000, 16'h7fff, 1'b1);
    // bias add wraps past max
    push_item(FUNC_TERM, 8'd1,   16'd100,  16'h7fff, 1'b1);
    // multi-term row, mid-row bias ignored, load in the middle keeps the sum
    push_item(FUNC_TERM, 8'd1,   16'd5,    16'h1234, 1'b0);
    push_item(FUNC_TERM, 8'd2,   16'd3,    16'h5555, 1'b0);
    push_item(FUNC_LOAD, 8'd3,   16'd7,    16'h7fff, 1'b1);
    push_item(FUNC_TERM, 8'd3,   16'hfffe, 16'h8000, 1'b1);
    // four times 2^30 wraps the 32-bit sum to zero
    repeat (3) push_item(FUNC_TERM, 8'd255, 16'h8000, 16'h0000, 1'b0);
    push_item(FUNC_TERM, 8'd255, 16'h8000, 16'h0001, 1'b1);
    // mid-magnitude negative saturates low; small negative passes through
    push_item(FUNC_TERM, 8'd170, 16'h8000, 16'h0000, 1'b1);
    push_item(FUNC_TERM, 8'd85,  16'd1,    16'h0000, 1'b1);

    // random phases across shift settings and idle/stall mixes
    run_phase(5'd31, 0,  0,  90, 1'b0);
    run_phase(5'd0,  59, 0,  90, 1'b1);
    run_phase(5'd16, 0,  59, 90, 1'b0);
    run_phase(SHIFT_W'($urandom_range(31)), 7, 7, 90, 1'b0);
    run_phase(SHIFT_W'($urandom_range(1, 30)), 0, 59, 90, 1'b0);

    drain();
    $display("summary: %0d items accepted (%0d loads, %0d terms), %0d row results checked",
             accepted_cnt, load_cnt, term_cnt, rows_checked);
    $display("summary: %0d shift writes, both extremes included, %0d mismatches",
             shift_writes, err_cnt);
    if (err_cnt == 0 && row_result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
